>>> src/rrm_pkg.sv
// Shared constants and types for the run-length encoded row map store.
package rrm_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam int PIXEL_W = 16;
  localparam int LEN_W   = 16;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int REG_W   = 7;
  localparam int COUNT_W = 7;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  localparam logic [LEN_W-1:0] MAX_RUN = 16'hFFFF;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic REG_COLUMN_COUNT = 1'b0;
  localparam logic REG_ROW_COUNT    = 1'b1;

  typedef struct packed {
    logic [PIXEL_W-1:0] value;
    logic [LEN_W-1:0]   length;
  } run_t;

endpackage

>>> src/rrm_cmd_if.sv
// Input item channel: pixel writes and pixel lookups.
interface rrm_cmd_if import rrm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [PIXEL_W-1:0] pixel_value;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   column;

  modport source(output valid, output op, output pixel_value, output row, output column,
                 input ready);
  modport sink(input valid, input op, input pixel_value, input row, input column,
               output ready);
endinterface

>>> src/rrm_res_if.sv
// Result item channel: lookup values and row completion status.
interface rrm_res_if import rrm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] value;
  logic               row_done;
  logic [COUNT_W-1:0] run_count;
  logic               map_done;

  modport source(output valid, output value, output row_done, output run_count,
                 output map_done, input ready);
  modport sink(input valid, input value, input row_done, input run_count,
               input map_done, output ready);
endinterface

>>> src/rle_row_map_store_lookup_core.sv
// Run-length encoded row map store with random-access pixel lookup.
// Pixel writes are taken one per cycle while each result is read as it appears; the write that
// completes a row then moves to a flush state, which stores its last run and records the row's
// run count. A lookup first reads the row's run count, then scans the row's runs in order (at
// most MAX_COLS of them) until the covering run or the row's last run is reached, through the
// single read port of the run memory, which delivers one run per cycle. A lookup of a row with
// no stored runs answers without reading the run memory. No new item is taken while a lookup
// is in progress. After reset the block clears every entry of the run-count memory, during which
// no item is accepted; configuration writes are taken at all times outside reset. Each item gives
// exactly one result item. A finished result waits in an output register, and the next item is
// taken only in a cycle in which that register is empty or being read.
module rle_row_map_store_lookup_core import rrm_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  rrm_cmd_if.sink           cmd,
  rrm_res_if.source         res
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int NW    = $clog2(MAX_COLS + 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = LEN_W + NW;
  localparam int CCW   = (NW > REG_W) ? NW : REG_W;
  localparam int RCW   = (RNW > REG_W) ? RNW : REG_W;
  localparam int LRW   = (RNW > ROW_W) ? RNW : ROW_W;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_FLUSH  = 5'b00100,
    S_LK_CNT = 5'b01000,
    S_LK_RUN = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [REG_W-1:0]   column_count, row_count;
  logic [PIXEL_W-1:0] open_val, open_val_next;
  logic [LEN_W-1:0]   open_len, open_len_next;
  logic [RW-1:0]      write_row, write_row_next;
  logic [NW-1:0]      write_col, write_col_next;
  logic [NW-1:0]      runs, runs_next;
  logic [RW-1:0]      clr_addr, clr_addr_next;
  logic               res_valid, res_valid_next;

  logic [PIXEL_W-1:0] res_value, res_value_next;
  logic               res_row_done, res_row_done_next;
  logic [COUNT_W-1:0] res_run_count, res_run_count_next;
  logic               res_map_done, res_map_done_next;
  logic               res_load;

  logic [RW-1:0]      lk_row, lk_row_next;
  logic [COL_W-1:0]   lk_col, lk_col_next;
  logic               lk_oor, lk_oor_next;
  logic [NW-1:0]      lk_k, lk_k_next;
  logic [NW-1:0]      lk_n, lk_n_next;
  logic [EW-1:0]      end_acc, end_acc_next;

  run_t               run_mem [DEPTH];
  logic [NW-1:0]      cnt_mem [MAX_ROWS];
  run_t               run_rdata;
  logic [NW-1:0]      cnt_rdata;

  logic               run_we, run_re, cnt_we, cnt_re;
  logic [AW-1:0]      run_waddr, run_raddr;
  run_t               run_wdata;
  logic [RW-1:0]      cnt_waddr, cnt_raddr;
  logic [NW-1:0]      cnt_wdata;

  logic [NW-1:0]      cols_eff, wc_inc, runs_final;
  logic [RNW-1:0]     rows_eff, row_inc;
  logic [CCW-1:0]     cols_wide;
  logic [RCW-1:0]     rows_wide;
  logic [EW-1:0]      run_sum;
  logic               out_free, accept, flush_store, wrap;

  function automatic logic [AW-1:0] run_addr(input logic [RW-1:0] r, input logic [NW-1:0] k);
    return AW'(r) * AW'(MAX_COLS) + AW'(k);
  endfunction

  assign pready = 1'b1;
  assign prdata = {{(APB_DW - REG_W){1'b0}},
                   (paddr[2] == REG_ROW_COUNT) ? row_count : column_count};

  assign cols_wide = CCW'(column_count);
  assign rows_wide = RCW'(row_count);
  assign cols_eff  = (column_count == '0) ? NW'(1) :
                     (cols_wide > CCW'(MAX_COLS)) ? NW'(MAX_COLS) : NW'(column_count);
  assign rows_eff  = (row_count == '0) ? RNW'(1) :
                     (rows_wide > RCW'(MAX_ROWS)) ? RNW'(MAX_ROWS) : RNW'(row_count);

  assign out_free  = !res_valid || res.ready;
  assign cmd.ready = (state == S_IDLE) && out_free;
  assign accept    = cmd.valid && cmd.ready;

  assign wc_inc      = write_col + NW'(1);
  assign flush_store = runs < NW'(MAX_COLS);
  assign runs_final  = flush_store ? runs + NW'(1) : runs;
  assign row_inc     = RNW'(write_row) + RNW'(1);
  assign wrap        = row_inc >= rows_eff;
  assign run_sum     = end_acc + EW'(run_rdata.length);

  assign res.valid     = res_valid;
  assign res.value     = res_value;
  assign res.row_done  = res_row_done;
  assign res.run_count = res_run_count;
  assign res.map_done  = res_map_done;

  always_comb begin
    state_next         = state;
    open_val_next      = open_val;
    open_len_next      = open_len;
    write_row_next     = write_row;
    write_col_next     = write_col;
    runs_next          = runs;
    clr_addr_next      = clr_addr;
    res_valid_next     = res_valid && !res.ready;
    res_load           = 1'b0;
    res_value_next     = '0;
    res_row_done_next  = 1'b0;
    res_run_count_next = '0;
    res_map_done_next  = 1'b0;
    lk_row_next        = lk_row;
    lk_col_next        = lk_col;
    lk_oor_next        = lk_oor;
    lk_k_next          = lk_k;
    lk_n_next          = lk_n;
    end_acc_next       = end_acc;
    run_we             = 1'b0;
    run_waddr          = '0;
    run_wdata          = '0;
    run_re             = 1'b0;
    run_raddr          = '0;
    cnt_we             = 1'b0;
    cnt_waddr          = '0;
    cnt_wdata          = '0;
    cnt_re             = 1'b0;
    cnt_raddr          = '0;

    case (state)
      S_CLEAR: begin
        cnt_we        = 1'b1;
        cnt_waddr     = clr_addr;
        clr_addr_next = clr_addr + RW'(1);
        if (clr_addr == RW'(MAX_ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (cmd.op == OP_LOOKUP) begin
            lk_row_next = RW'(cmd.row);
            lk_col_next = cmd.column;
            lk_oor_next = LRW'(cmd.row) >= LRW'(MAX_ROWS);
            cnt_re      = 1'b1;
            cnt_raddr   = RW'(cmd.row);
            state_next  = S_LK_CNT;
          end else begin
            if (open_len == '0) begin
              open_val_next = cmd.pixel_value;
              open_len_next = LEN_W'(1);
            end else if (cmd.pixel_value == open_val && open_len != MAX_RUN) begin
              open_len_next = open_len + LEN_W'(1);
            end else begin
              if (flush_store) begin
                run_we    = 1'b1;
                run_waddr = run_addr(write_row, runs);
                run_wdata = '{value: open_val, length: open_len};
                runs_next = runs + NW'(1);
              end
              open_val_next = cmd.pixel_value;
              open_len_next = LEN_W'(1);
            end
            write_col_next = wc_inc;
            if (wc_inc >= cols_eff) begin
              state_next = S_FLUSH;
            end else begin
              res_load       = 1'b1;
              res_valid_next = 1'b1;
            end
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          if (flush_store) begin
            run_we    = 1'b1;
            run_waddr = run_addr(write_row, runs);
            run_wdata = '{value: open_val, length: open_len};
          end
          cnt_we             = 1'b1;
          cnt_waddr          = write_row;
          cnt_wdata          = runs_final;
          res_load           = 1'b1;
          res_valid_next     = 1'b1;
          res_row_done_next  = 1'b1;
          res_run_count_next = COUNT_W'(runs_final);
          res_map_done_next  = wrap;
          open_val_next      = '0;
          open_len_next      = '0;
          write_col_next     = '0;
          runs_next          = '0;
          write_row_next     = wrap ? '0 : RW'(row_inc);
          state_next         = S_IDLE;
        end
      end
      S_LK_CNT: begin
        if (lk_oor || cnt_rdata == '0) begin
          if (out_free) begin
            res_load       = 1'b1;
            res_valid_next = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          lk_n_next    = cnt_rdata;
          lk_k_next    = '0;
          end_acc_next = '0;
          run_re       = 1'b1;
          run_raddr    = run_addr(lk_row, '0);
          state_next   = S_LK_RUN;
        end
      end
      S_LK_RUN: begin
        if (EW'(lk_col) < run_sum) begin
          if (out_free) begin
            res_load       = 1'b1;
            res_valid_next = 1'b1;
            res_value_next = run_rdata.value;
            state_next     = S_IDLE;
          end
        end else if (lk_k + NW'(1) == lk_n) begin
          if (out_free) begin
            res_load       = 1'b1;
            res_valid_next = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          end_acc_next = run_sum;
          lk_k_next    = lk_k + NW'(1);
          run_re       = 1'b1;
          run_raddr    = run_addr(lk_row, lk_k + NW'(1));
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      column_count <= REG_W'(MAX_COLS_DEF);
      row_count    <= REG_W'(MAX_ROWS_DEF);
      open_val     <= '0;
      open_len     <= '0;
      write_row    <= '0;
      write_col    <= '0;
      runs         <= '0;
      clr_addr     <= '0;
      res_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      open_val  <= open_val_next;
      open_len  <= open_len_next;
      write_row <= write_row_next;
      write_col <= write_col_next;
      runs      <= runs_next;
      clr_addr  <= clr_addr_next;
      res_valid <= res_valid_next;
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_ROW_COUNT) begin
          row_count <= pwdata[REG_W-1:0];
        end else begin
          column_count <= pwdata[REG_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    lk_row  <= lk_row_next;
    lk_col  <= lk_col_next;
    lk_oor  <= lk_oor_next;
    lk_k    <= lk_k_next;
    lk_n    <= lk_n_next;
    end_acc <= end_acc_next;
    if (res_load) begin
      res_value     <= res_value_next;
      res_row_done  <= res_row_done_next;
      res_run_count <= res_run_count_next;
      res_map_done  <= res_map_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (run_we) begin
      run_mem[run_waddr] <= run_wdata;
    end
    if (run_re) begin
      run_rdata <= run_mem[run_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata <= cnt_mem[cnt_raddr];
    end
  end

endmodule
